@@ sv/sort_values_by_keys_core_macros.svh @@
// Assertion helpers for the key sorter.
`ifndef SORT_VALUES_BY_KEYS_CORE_MACROS_SVH
`define SORT_VALUES_BY_KEYS_CORE_MACROS_SVH

// same-cycle implication
`define SVBK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("svbk check failed");

// next-cycle implication
`define SVBK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("svbk check failed");

`endif

@@ sv/svbk_pkg.sv @@
package svbk_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int PAY_W        = 32;
  localparam int KEY_W        = 64;

  typedef enum logic {
    ST_LOAD,
    ST_DRAIN
  } state_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic load;
    logic drain;
  } cell_ctrl_t;

endpackage

@@ sv/sort_values_by_keys_core.sv @@
// Loading: one pair per cycle in the load state, each inserted into the cell chain.
// The first result is offered in the cycle after the final pair's transfer.
// Draining: N stored pairs emit N results, one per cycle while out_ready is high.
// Then loading resumes; no pair is taken while a set drains through the chain.
// Reset (rst_n, synchronous): clears cell valid bits, fill count, drop flag and state;
// key and payload registers are not reset.
`include "sort_values_by_keys_core_macros.svh"

module sort_values_by_keys_core #(
  parameter int CAPACITY = svbk_pkg::CAPACITY_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [svbk_pkg::PAY_W-1:0] in_payload,
  input  logic signed [svbk_pkg::KEY_W-1:0] in_sort_key,
  input  logic                              in_final_pair,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [svbk_pkg::PAY_W-1:0] out_sorted_payload,
  output logic                              out_final_result,
  output logic                              out_overflow
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  svbk_pkg::state_t     state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic                 dropped_r, dropped_nxt;
  svbk_pkg::cell_ctrl_t ctrl;

  logic                              in_xfer, out_xfer, full, last_out;
  logic                              ins_a   [CAPACITY];
  logic                              valid_a [CAPACITY];
  logic signed [svbk_pkg::KEY_W-1:0] key_a   [CAPACITY];
  logic signed [svbk_pkg::PAY_W-1:0] pay_a   [CAPACITY];

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;
  assign full     = (count_r == CNT_W'(CAPACITY));
  assign last_out = (count_r == CNT_W'(1));

  assign ctrl.load  = in_xfer && !full;
  assign ctrl.drain = out_xfer;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      logic                              p_ins, p_valid, n_valid;
      logic signed [svbk_pkg::KEY_W-1:0] p_key, n_key;
      logic signed [svbk_pkg::PAY_W-1:0] p_pay, n_pay;

      if (gi == 0) begin : g_head
        assign p_ins   = 1'b0;
        assign p_valid = 1'b0;
        assign p_key   = '0;
        assign p_pay   = '0;
      end else begin : g_body
        assign p_ins   = ins_a[gi-1];
        assign p_valid = valid_a[gi-1];
        assign p_key   = key_a[gi-1];
        assign p_pay   = pay_a[gi-1];
      end

      if (gi == CAPACITY - 1) begin : g_tail
        assign n_valid = 1'b0;
        assign n_key   = '0;
        assign n_pay   = '0;
      end else begin : g_mid
        assign n_valid = valid_a[gi+1];
        assign n_key   = key_a[gi+1];
        assign n_pay   = pay_a[gi+1];
      end

      svbk_cell u_cell (
        .clk          (clk),
        .rst_n        (rst_n),
        .ctrl_i       (ctrl),
        .new_key_i    (in_sort_key),
        .new_pay_i    (in_payload),
        .prev_ins_i   (p_ins),
        .prev_valid_i (p_valid),
        .prev_key_i   (p_key),
        .prev_pay_i   (p_pay),
        .next_valid_i (n_valid),
        .next_key_i   (n_key),
        .next_pay_i   (n_pay),
        .ins_o        (ins_a[gi]),
        .valid_o      (valid_a[gi]),
        .key_o        (key_a[gi]),
        .pay_o        (pay_a[gi])
      );
    end
  endgenerate

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      svbk_pkg::ST_LOAD:  if (in_xfer && in_final_pair) state_nxt = svbk_pkg::ST_DRAIN;
      svbk_pkg::ST_DRAIN: if (out_xfer && last_out) state_nxt = svbk_pkg::ST_LOAD;
      default:            state_nxt = svbk_pkg::ST_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      svbk_pkg::ST_LOAD:  in_ready  = 1'b1;
      svbk_pkg::ST_DRAIN: out_valid = 1'b1;
      default:            in_ready  = 1'b0;
    endcase
  end

  always_comb begin
    count_nxt   = count_r;
    dropped_nxt = dropped_r;
    if (ctrl.load) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (out_xfer) begin
      count_nxt = count_r - CNT_W'(1);
    end
    if (in_xfer && full) begin
      dropped_nxt = 1'b1;
    end else if (out_xfer && last_out) begin
      dropped_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= svbk_pkg::ST_LOAD;
      count_r   <= '0;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      dropped_r <= dropped_nxt;
    end
  end

  assign out_sorted_payload = pay_a[0];
  assign out_final_result   = last_out;
  assign out_overflow       = dropped_r;

  `SVBK_ASSERT_NOW(a_one_side, out_valid, !in_ready)
  `SVBK_ASSERT_NOW(a_head_valid, out_valid, valid_a[0] && (count_r != '0))
  `SVBK_ASSERT_NOW(a_count_cap, 1'b1, count_r <= CNT_W'(CAPACITY))
  `SVBK_ASSERT_NEXT(a_set_done, out_xfer && out_final_result, in_ready && !out_overflow)

endmodule

@@ sv/svbk_cell.sv @@
module svbk_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  svbk_pkg::cell_ctrl_t                ctrl_i,
  input  logic signed [svbk_pkg::KEY_W-1:0]   new_key_i,
  input  logic signed [svbk_pkg::PAY_W-1:0]   new_pay_i,
  input  logic                                prev_ins_i,
  input  logic                                prev_valid_i,
  input  logic signed [svbk_pkg::KEY_W-1:0]   prev_key_i,
  input  logic signed [svbk_pkg::PAY_W-1:0]   prev_pay_i,
  input  logic                                next_valid_i,
  input  logic signed [svbk_pkg::KEY_W-1:0]   next_key_i,
  input  logic signed [svbk_pkg::PAY_W-1:0]   next_pay_i,
  output logic                                ins_o,
  output logic                                valid_o,
  output logic signed [svbk_pkg::KEY_W-1:0]   key_o,
  output logic signed [svbk_pkg::PAY_W-1:0]   pay_o
);

  logic                              valid_r, valid_nxt;
  logic signed [svbk_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [svbk_pkg::PAY_W-1:0] pay_r, pay_nxt;

  // strictly greater keeps equal keys ahead of the new pair
  assign ins_o = !valid_r || (key_r > new_key_i);

  always_comb begin
    valid_nxt = valid_r;
    key_nxt   = key_r;
    pay_nxt   = pay_r;
    if (ctrl_i.load) begin
      if (ins_o && !prev_ins_i) begin
        valid_nxt = 1'b1;
        key_nxt   = new_key_i;
        pay_nxt   = new_pay_i;
      end else if (ins_o && prev_ins_i) begin
        valid_nxt = prev_valid_i;
        key_nxt   = prev_key_i;
        pay_nxt   = prev_pay_i;
      end
    end else if (ctrl_i.drain) begin
      valid_nxt = next_valid_i;
      key_nxt   = next_key_i;
      pay_nxt   = next_pay_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    pay_r <= pay_nxt;
  end

  assign valid_o = valid_r;
  assign key_o   = key_r;
  assign pay_o   = pay_r;

endmodule

@@ verif/tb.sv @@
typedef logic signed [svbk_pkg::KEY_W-1:0] key_t;
typedef logic signed [svbk_pkg::PAY_W-1:0] pay_t;

typedef struct {
  pay_t payload;
  logic final_result;
  logic overflow;
} emitted_t;

// Tracks the sorting chain and the payloads it owes on each set close.
class payload_order_board;
  key_t        keys[svbk_pkg::CAPACITY_DEF];
  pay_t        vals[svbk_pkg::CAPACITY_DEF];
  int unsigned fill;
  bit          dropped;
  emitted_t    owed[$];
  int unsigned mismatches;
  int unsigned pairs_taken;
  int unsigned sets_closed;
  int unsigned sets_truncated;
  int unsigned results_seen;

  function void note_pair(pay_t p, key_t k, logic fin);
    int unsigned pos;
    emitted_t    e;
    pairs_taken++;
    if (fill < svbk_pkg::CAPACITY_DEF) begin
      pos = fill;
      // strict compare keeps equal keys in arrival order
      while (pos > 0 && keys[pos-1] > k) begin
        keys[pos] = keys[pos-1];
        vals[pos] = vals[pos-1];
        pos--;
      end
      keys[pos] = k;
      vals[pos] = p;
      fill++;
    end else begin
      dropped = 1'b1;
    end
    if (fin) begin
      for (int unsigned i = 0; i < fill; i++) begin
        e.payload      = vals[i];
        e.final_result = (i + 1 == fill);
        e.overflow     = dropped;
        owed.push_back(e);
      end
      sets_closed++;
      if (dropped) sets_truncated++;
      fill    = 0;
      dropped = 1'b0;
    end
  endfunction

  function void check_result(pay_t p, logic fin, logic ovf);
    emitted_t e;
    results_seen++;
    if (owed.size() == 0) begin
      $error("unexpected result: sorted_payload %0d final_result %0b overflow %0b",
             p, fin, ovf);
      mismatches++;
      return;
    end
    e = owed.pop_front();
    if (p !== e.payload) begin
      $error("sorted_payload: expected %0d, got %0d", e.payload, p);
      mismatches++;
    end
    if (fin !== e.final_result) begin
      $error("final_result: expected %0b, got %0b", e.final_result, fin);
      mismatches++;
    end
    if (ovf !== e.overflow) begin
      $error("overflow: expected %0b, got %0b", e.overflow, ovf);
      mismatches++;
    end
  endfunction
endclass

module tb;
  localparam int   STALL_LIMIT = 2000;
  localparam key_t KEY_MAX     = {1'b0, {63{1'b1}}};
  localparam key_t KEY_MIN     = {1'b1, {63{1'b0}}};
  localparam key_t ONE_Q       = 64'sh0000_0001_0000_0000;
  localparam pay_t PAY_MAX     = {1'b0, {31{1'b1}}};
  localparam pay_t PAY_MIN     = {1'b1, {31{1'b0}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pay_t in_payload = '0;
  key_t in_sort_key = '0;
  logic in_final_pair = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  pay_t out_sorted_payload;
  logic out_final_result;
  logic out_overflow;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int quiet_cycles = 0;

  payload_order_board board = new();

  sort_values_by_keys_core dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_payload        (in_payload),
    .in_sort_key       (in_sort_key),
    .in_final_pair     (in_final_pair),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_sorted_payload(out_sorted_payload),
    .out_final_result  (out_final_result),
    .out_overflow      (out_overflow)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_ready <= !(recv_stall_pct != 0 && $urandom_range(99) < recv_stall_pct);
  end

  // results first: a set's output never shares an edge with its own final pair
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready)
        board.check_result(out_sorted_payload, out_final_result, out_overflow);
      if (in_valid && in_ready)
        board.note_pair(in_payload, in_sort_key, in_final_pair);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic key_t rand_key();
    case ($urandom_range(5))
      0: return key_t'(int'($urandom_range(4)) - 2);
      1: return $urandom_range(1) ? KEY_MAX : KEY_MIN;
      2: return (key_t'(int'($urandom_range(6)) - 3) <<< 32) | key_t'({32'b0, $urandom});
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic pay_t rand_payload();
    if ($urandom_range(7) == 0) return $urandom_range(1) ? PAY_MAX : PAY_MIN;
    return $urandom;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic push_pair(input pay_t p, input key_t k, input logic fin);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_payload    <= p;
    in_sort_key   <= k;
    in_final_pair <= fin;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic push_random_set(input int len);
    for (int i = 0; i < len; i++)
      push_pair(rand_payload(), rand_key(), i == len - 1);
  endtask

  initial begin
    int taken;
    int nsets;
    int len;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // single-pair sets at the extremes
    push_pair(PAY_MAX, KEY_MAX, 1'b1);
    push_pair(PAY_MIN, KEY_MIN, 1'b1);
    // mixed signs, Q32.32 unit values, ties on zero and on the minimum
    push_pair(10, 0, 1'b0);
    push_pair(11, KEY_MAX, 1'b0);
    push_pair(12, KEY_MIN, 1'b0);
    push_pair(13, -1, 1'b0);
    push_pair(14, 1, 1'b0);
    push_pair(15, ONE_Q, 1'b0);
    push_pair(16, -ONE_Q, 1'b0);
    push_pair(17, 0, 1'b0);
    push_pair(18, KEY_MIN, 1'b1);
    // reverse order arrival
    for (int i = 5; i >= 1; i--) push_pair(-i, i, i == 1);
    // run of equal keys must keep arrival order
    push_pair(0, 7, 1'b0);
    push_pair(PAY_MAX, 7, 1'b0);
    push_pair(PAY_MIN, 7, 1'b0);
    push_pair(-1, 8, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase
      taken = 0;
      nsets = 0;
      while (taken < 78) begin
        // one exactly full set, one that spills past capacity
        if (ph == 1 && nsets == 0) len = svbk_pkg::CAPACITY_DEF;
        else if (ph == 3 && nsets == 0) len = svbk_pkg::CAPACITY_DEF + 2;
        else if ($urandom_range(15) == 0) len = $urandom_range(62, 70);
        else len = $urandom_range(1, 12);
        push_random_set(len);
        taken += len;
        nsets++;
      end
    end
    in_valid <= 1'b0;

    while (board.owed.size() != 0) @(posedge clk);
    repeat (svbk_pkg::CAPACITY_DEF + 8) @(posedge clk);

    if (board.owed.size() != 0) begin
      $error("%0d results never arrived", board.owed.size());
      board.mismatches++;
    end
    $display("run covered %0d pairs in %0d sets (%0d truncated), %0d results checked",
             board.pairs_taken, board.sets_closed, board.sets_truncated,
             board.results_seen);
    $display("field mismatches or stray results: %0d", board.mismatches);
    if (board.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
